FILE: rtl/core/tevq_pkg.sv
// Shared types and constants for the touch event qualifier.
// Register indexes, reset values, event kinds and the stage structs.
// No dependencies.
package tevq_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned RAW_W      = 16;
	localparam int unsigned DELTA_W    = 13;
	localparam int unsigned TICKS_W    = 16;
	localparam int unsigned THR_SQ_W   = 2 * COORD_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PANEL_WIDTH       = 3'd0,
		REG_PANEL_HEIGHT      = 3'd1,
		REG_MIRROR_HORIZONTAL = 3'd2,
		REG_MIRROR_VERTICAL   = 3'd3,
		REG_MOVE_THRESHOLD    = 3'd4,
		REG_RELEASE_TIMEOUT   = 3'd5,
		REG_EVENT_ENABLE      = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_DOWN = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_UP   = 2'd2
	} kind_t;

	localparam logic [COORD_W-1:0]  RST_PANEL_WIDTH     = 12'd480;
	localparam logic [COORD_W-1:0]  RST_PANEL_HEIGHT    = 12'd480;
	localparam logic                RST_MIRROR_H        = 1'b1;
	localparam logic                RST_MIRROR_V        = 1'b1;
	localparam logic [COORD_W-1:0]  RST_MOVE_THRESHOLD  = 12'd4;
	localparam logic [THR_SQ_W-1:0] RST_THR_SQ          = 24'd16;
	localparam logic [TICKS_W-1:0]  RST_RELEASE_TIMEOUT = 16'd100;
	localparam logic                RST_EVENT_ENABLE    = 1'b1;

	// status byte fields
	localparam int unsigned STATUS_READY_BIT = 7;
	localparam logic [7:0]  STATUS_COUNT_MASK = 8'h0F;

	typedef struct packed {
		logic [COORD_W-1:0]  panel_width;
		logic [COORD_W-1:0]  panel_height;
		logic                mirror_h;
		logic                mirror_v;
		logic [THR_SQ_W-1:0] thr_sq;
		logic [TICKS_W-1:0]  release_timeout;
		logic                event_enable;
	} cfg_t;

	// decoded, mapped report heading into the state stage
	typedef struct packed {
		logic               valid;
		logic               func;
		logic               rdy;
		logic               contact;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} mapped_t;

endpackage

FILE: rtl/core/tevq_in_if.sv
// Input item channel: valid/ready plus one tick or controller report.
// Depends on tevq_pkg for field widths.
interface tevq_in_if;
	import tevq_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [7:0]       status_byte;
	logic             point_read_ok;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, func, status_byte, point_read_ok, raw_x, raw_y,
		input ready);
	modport sink (input valid, func, status_byte, point_read_ok, raw_x, raw_y,
		output ready);
endinterface

FILE: rtl/core/tevq_out_if.sv
// Result channel: valid/ready plus one event record.
// Depends on tevq_pkg for field widths.
interface tevq_out_if;
	import tevq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      event_valid;
	logic [1:0]                event_kind;
	logic [COORD_W-1:0]        pos_x;
	logic [COORD_W-1:0]        pos_y;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic                      is_pressed;

	modport source (output valid, event_valid, event_kind, pos_x, pos_y, delta_x,
		delta_y, is_pressed, input ready);
	modport sink (input valid, event_valid, event_kind, pos_x, pos_y, delta_x,
		delta_y, is_pressed, output ready);
endinterface

FILE: rtl/core/tevq_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on tevq_pkg for field widths.
interface tevq_cfg_if;
	import tevq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tevq_cfg_regs.sv
// Configuration register file of the touch event qualifier.
// Depends on tevq_pkg and tevq_cfg_if.
module tevq_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	tevq_cfg_if.sink       cfg,
	output tevq_pkg::cfg_t regs
);
	import tevq_pkg::*;

	cfg_t                regs_q;
	logic                wr;
	logic [THR_SQ_W-1:0] thr_w;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;
	assign regs      = regs_q;
	assign thr_w     = {{(THR_SQ_W-COORD_W){1'b0}}, cfg.data[COORD_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.panel_width     <= RST_PANEL_WIDTH;
			regs_q.panel_height    <= RST_PANEL_HEIGHT;
			regs_q.mirror_h        <= RST_MIRROR_H;
			regs_q.mirror_v        <= RST_MIRROR_V;
			regs_q.thr_sq          <= RST_THR_SQ;
			regs_q.release_timeout <= RST_RELEASE_TIMEOUT;
			regs_q.event_enable    <= RST_EVENT_ENABLE;
		end else if (wr) begin
			case (cfg.index)
				REG_PANEL_WIDTH:       regs_q.panel_width  <= cfg.data[COORD_W-1:0];
				REG_PANEL_HEIGHT:      regs_q.panel_height <= cfg.data[COORD_W-1:0];
				REG_MIRROR_HORIZONTAL: regs_q.mirror_h     <= cfg.data[0];
				REG_MIRROR_VERTICAL:   regs_q.mirror_v     <= cfg.data[0];
				// only the square is ever compared against
				REG_MOVE_THRESHOLD: regs_q.thr_sq <= thr_w * thr_w;
				REG_RELEASE_TIMEOUT: regs_q.release_timeout <= cfg.data[TICKS_W-1:0];
				REG_EVENT_ENABLE:    regs_q.event_enable    <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/tevq_map.sv
// Input register, report decode and coordinate mirror/clamp stage.
// Depends on tevq_pkg and tevq_in_if.
module tevq_map (
	input  logic              clk,
	input  logic              arst_n,
	tevq_in_if.sink           item,
	input  tevq_pkg::cfg_t    regs,
	input  logic              take,
	output tevq_pkg::mapped_t mapped
);
	import tevq_pkg::*;

	logic             v_s1;
	logic             func_s1;
	logic [7:0]       status_s1;
	logic             ok_s1;
	logic [RAW_W-1:0] rx_s1;
	logic [RAW_W-1:0] ry_s1;
	mapped_t          m_s2;
	logic             s2_free;
	logic             s1_free;
	logic             s1_move;
	mapped_t          m_next;

	function automatic logic [COORD_W-1:0] map_axis(
		input logic [RAW_W-1:0]   raw,
		input logic [COORD_W-1:0] size,
		input logic               mirror
	);
		logic [RAW_W-1:0]   v;
		logic [RAW_W-1:0]   size_w;
		logic [COORD_W-1:0] top;
		size_w = {{(RAW_W-COORD_W){1'b0}}, size};
		if (mirror) begin
			v = (raw > size_w) ? '0 : size_w - raw;
		end else begin
			v = raw;
		end
		top = (size == '0) ? '0 : size - 1'b1;
		return (v > {{(RAW_W-COORD_W){1'b0}}, top}) ? top : v[COORD_W-1:0];
	endfunction

	assign s2_free    = !m_s2.valid || take;
	assign s1_free    = !v_s1 || s2_free;
	assign s1_move    = v_s1 && s2_free;
	assign item.ready = s1_free;
	assign mapped     = m_s2;

	always_comb begin
		m_next.valid   = 1'b1;
		m_next.func    = func_s1;
		m_next.rdy     = status_s1[STATUS_READY_BIT];
		// a failed point read counts as no contact
		m_next.contact = ((status_s1 & STATUS_COUNT_MASK) != 8'd0) && ok_s1;
		m_next.px      = map_axis(rx_s1, regs.panel_width, regs.mirror_h);
		m_next.py      = map_axis(ry_s1, regs.panel_height, regs.mirror_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && s1_free) begin
			func_s1   <= item.func;
			status_s1 <= item.status_byte;
			ok_s1     <= item.point_read_ok;
			rx_s1     <= item.raw_x;
			ry_s1     <= item.raw_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_s2 <= '0;
		end else begin
			if (s2_free) begin
				m_s2.valid <= v_s1;
			end
			if (s1_move) begin
				m_s2.func    <= m_next.func;
				m_s2.rdy     <= m_next.rdy;
				m_s2.contact <= m_next.contact;
				m_s2.px      <= m_next.px;
				m_s2.py      <= m_next.py;
			end
		end
	end

endmodule

FILE: rtl/core/tevq_fsm.sv
// Down/move/up state, release timeout and result register.
// Depends on tevq_pkg and tevq_out_if.
module tevq_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  tevq_pkg::mapped_t mapped,
	input  tevq_pkg::cfg_t    regs,
	output logic              take,
	tevq_out_if.source        result
);
	import tevq_pkg::*;

	logic               pressed_q;
	logic [COORD_W-1:0] ex_q;
	logic [COORD_W-1:0] ey_q;
	logic [TICKS_W-1:0] idle_q;
	logic               res_v_q;

	logic               consume;
	logic [TICKS_W:0]   next_idle;
	logic [DELTA_W-1:0] dx;
	logic [DELTA_W-1:0] dy;
	logic [DELTA_W-1:0] ndx;
	logic [DELTA_W-1:0] ndy;
	logic [COORD_W-1:0] adx;
	logic [COORD_W-1:0] ady;
	logic [THR_SQ_W-1:0] adx_w;
	logic [THR_SQ_W-1:0] ady_w;
	logic [THR_SQ_W-1:0] sq_x;
	logic [THR_SQ_W-1:0] sq_y;
	logic [THR_SQ_W:0]  d2;

	logic               ev;
	kind_t              kind;
	logic               pressed_n;
	logic [COORD_W-1:0] ex_n;
	logic [COORD_W-1:0] ey_n;
	logic [TICKS_W-1:0] idle_n;

	assign take         = !res_v_q || result.ready;
	assign consume      = mapped.valid && take;
	assign result.valid = res_v_q;

	assign next_idle = {1'b0, idle_q} + 1'b1;
	assign dx    = {1'b0, mapped.px} - {1'b0, ex_q};
	assign dy    = {1'b0, mapped.py} - {1'b0, ey_q};
	assign ndx   = -dx;
	assign ndy   = -dy;
	assign adx   = dx[DELTA_W-1] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
	assign ady   = dy[DELTA_W-1] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
	assign adx_w = {{(THR_SQ_W-COORD_W){1'b0}}, adx};
	assign ady_w = {{(THR_SQ_W-COORD_W){1'b0}}, ady};
	assign sq_x  = adx_w * adx_w;
	assign sq_y  = ady_w * ady_w;
	assign d2    = {1'b0, sq_x} + {1'b0, sq_y};

	always_comb begin
		ev        = 1'b0;
		kind      = KIND_DOWN;
		pressed_n = pressed_q;
		ex_n      = ex_q;
		ey_n      = ey_q;
		idle_n    = '0;
		if (!mapped.func) begin
			if (pressed_q) begin
				if (next_idle >= {1'b0, regs.release_timeout}) begin
					pressed_n = 1'b0;
					ev        = 1'b1;
					kind      = KIND_UP;
				end else begin
					idle_n = next_idle[TICKS_W-1:0];
				end
			end
		end else if (mapped.rdy) begin
			if (mapped.contact) begin
				if (!pressed_q) begin
					pressed_n = 1'b1;
					ex_n      = mapped.px;
					ey_n      = mapped.py;
					ev        = 1'b1;
					kind      = KIND_DOWN;
				end else if (d2 >= {1'b0, regs.thr_sq}) begin
					ex_n = mapped.px;
					ey_n = mapped.py;
					ev   = 1'b1;
					kind = KIND_MOVE;
				end
			end else if (pressed_q) begin
				pressed_n = 1'b0;
				ev        = 1'b1;
				kind      = KIND_UP;
			end
		end
		if (!regs.event_enable) begin
			ev = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			ex_q      <= '0;
			ey_q      <= '0;
			idle_q    <= '0;
			res_v_q   <= 1'b0;
		end else begin
			if (consume) begin
				pressed_q <= pressed_n;
				ex_q      <= ex_n;
				ey_q      <= ey_n;
				idle_q    <= idle_n;
			end
			if (take) begin
				res_v_q <= mapped.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			result.event_valid <= ev;
			result.event_kind  <= ev ? kind : KIND_DOWN;
			result.pos_x       <= ex_n;
			result.pos_y       <= ey_n;
			result.delta_x     <= (ev && kind == KIND_MOVE) ? dx : '0;
			result.delta_y     <= (ev && kind == KIND_MOVE) ? dy : '0;
			result.is_pressed  <= pressed_n;
		end
	end

endmodule

FILE: rtl/core/touch_event_qualifier.sv
// Top level of the touch event qualifier: config registers, mapping stage, event stage.
// Depends on tevq_pkg, the three channel interfaces, tevq_cfg_regs, tevq_map, tevq_fsm.
//
// Takes one item per clock (a 1 ms tick or a controller report) while the result side
// does not stall, and returns exactly one result per item. An accepted request passes
// an input register, a mapping register (mirror and clamp of the coordinates) and then
// the result register behind the down/move/up state update, from which it goes out on
// the result port. The rate of one item per cycle is set by the state update loop,
// which holds the pressed flag, the last emitted point and the idle tick counter; the
// move test compares the squared distance against the threshold squared, which is
// computed when the threshold register is written. Configuration writes are always
// ready and should only be issued while no request is in flight.
module touch_event_qualifier (
	input  logic        clk,
	input  logic        arst_n,
	tevq_cfg_if.sink    cfg,
	tevq_in_if.sink     item,
	tevq_out_if.source  result
);
	import tevq_pkg::*;

	cfg_t    regs;
	mapped_t mapped;
	logic    take;

	tevq_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tevq_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.regs   (regs),
		.take   (take),
		.mapped (mapped)
	);

	tevq_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.mapped (mapped),
		.regs   (regs),
		.take   (take),
		.result (result)
	);

endmodule
